// File: rtl/xor_linear_basis_unit_defines.svh
// Assertion macros shared by the checker of the XOR linear basis unit.
// No dependencies.
`ifndef XOR_LINEAR_BASIS_UNIT_DEFINES_SVH
`define XOR_LINEAR_BASIS_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define XLB_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define XLB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/xlb_pkg.sv
// Types and operation codes of the XOR linear basis unit.
// Used by the cell, the top level and the testbench; no dependencies.
package xlb_pkg;

  localparam logic [2:0] FN_INSERT = 3'd0;
  localparam logic [2:0] FN_MEMBER = 3'd1;
  localparam logic [2:0] FN_KTH    = 3'd2;
  localparam logic [2:0] FN_ORDER  = 3'd3;
  localparam logic [2:0] FN_MAX    = 3'd4;

  localparam logic [31:0] WORD_MAX = 32'hFFFF_FFFF;

  typedef struct packed {
    logic        valid;
    logic [2:0]  func;
    logic [31:0] x;
    logic [31:0] idx;
    logic [31:0] acc;
    logic [5:0]  left;
    logic        done;
    logic        oor;
  } tok_t;

endpackage

// File: rtl/xlb_cell.sv
// One basis slot of the chain together with its stage register.
// Depends on xlb_pkg.
module xlb_cell
  import xlb_pkg::*;
#(
  parameter int IDX = 0,
  parameter int DW  = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic advance,
  input  tok_t tok_i,
  output tok_t tok_o
);

  logic [DW-1:0] slot;
  logic          occ;
  tok_t          t_next;
  logic [31:0]   slot_ext;
  logic [5:0]    left_dec;
  logic          want;
  logic          place;

  always_comb begin
    t_next   = tok_i;
    slot_ext = 32'(slot);
    left_dec = tok_i.left - 6'd1;
    want     = tok_i.idx[left_dec[4:0]];
    place    = 1'b0;
    case (tok_i.func)
      FN_INSERT: begin
        if (!tok_i.done && tok_i.x[IDX]) begin
          if (occ) begin
            t_next.x = tok_i.x ^ slot_ext;
          end else begin
            t_next.done = 1'b1;
            place       = tok_i.valid;
          end
        end
      end
      FN_MEMBER: begin
        if (occ && tok_i.x[IDX]) begin
          t_next.x = tok_i.x ^ slot_ext;
        end
      end
      FN_KTH: begin
        if (occ) begin
          t_next.left = left_dec;
          if (want != tok_i.x[IDX]) begin
            t_next.x = tok_i.x ^ slot_ext;
          end
        end
      end
      FN_ORDER: begin
        if (occ) begin
          t_next.acc = {tok_i.acc[30:0], tok_i.x[IDX]};
        end
      end
      FN_MAX: begin
        if (occ && !tok_i.x[IDX]) begin
          t_next.x = tok_i.x ^ slot_ext;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= 1'b0;
    end else if (advance && place) begin
      occ <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && place) begin
      slot <= tok_i.x[DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_o.valid <= 1'b0;
    end else if (advance) begin
      tok_o <= t_next;
    end
  end

endmodule

// File: rtl/xor_linear_basis_unit.sv
// Top level of the XOR linear basis unit: entry stage, chain of slot cells, result register.
// Depends on xlb_pkg and xlb_cell.
//
//   channel  direction  handshake            word
//   input    in         in_valid / in_stall  func, operand
//   output   out        out_valid / out_stall result_value, is_member, out_of_range,
//                                            rank, dependent_count
//
// A word passes the entry stage, then one slot cell a cycle while the chain is not halted,
// from the top slot down, and its result is then registered in the result register.
// One word is in the chain at a time; the input stall drops as the result is registered,
// so the next word can be accepted in the same cycle that the result appears.
// The chain halts while a finished word waits behind a stalled result.
// Synchronous reset empties every slot and clears the rank and the insert count.
module xor_linear_basis_unit
  import xlb_pkg::*;
#(
  parameter int VEC_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  func,
  input  logic [31:0] operand,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] result_value,
  output logic        is_member,
  output logic        out_of_range,
  output logic [5:0]  rank,
  output logic [31:0] dependent_count
);

  localparam int DW = (VEC_WIDTH < 32) ? VEC_WIDTH : 32;
  localparam logic [31:0] OP_MASK = 32'((64'd1 << DW) - 64'd1);

  tok_t        chain [DW:0];
  tok_t        entry;
  logic        busy;
  logic        accept;
  logic        advance;
  logic        finish;
  logic [5:0]  basis_rank;
  logic [5:0]  rank_next;
  logic [31:0] insert_total;
  logic [31:0] value_next;
  logic [31:0] dep_next;
  logic        kth_bad;

  assign in_stall = busy;
  assign accept   = in_valid && !busy;
  assign advance  = !(chain[0].valid && out_valid && out_stall);
  assign finish   = chain[0].valid && advance;
  assign kth_bad  = (operand == 32'd0) || ({1'b0, operand} > (33'd1 << basis_rank));

  always_comb begin
    entry       = '0;
    entry.valid = 1'b1;
    entry.func  = func;
    entry.x     = (func == FN_KTH || func == FN_MAX) ? 32'd0 : (operand & OP_MASK);
    entry.idx   = operand - 32'd1;
    entry.left  = basis_rank;
    entry.oor   = (func == FN_KTH) && kth_bad;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chain[DW].valid <= 1'b0;
    end else if (accept) begin
      chain[DW] <= entry;
    end else if (advance) begin
      chain[DW].valid <= 1'b0;
    end
  end

  for (genvar i = 0; i < DW; i++) begin : g_cell
    xlb_cell #(
      .IDX (i),
      .DW  (DW)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .advance (advance),
      .tok_i   (chain[i+1]),
      .tok_o   (chain[i])
    );
  end

  always_comb begin
    rank_next = basis_rank + 6'((chain[0].func == FN_INSERT) && chain[0].done);
    case (chain[0].func)
      FN_KTH:   value_next = chain[0].oor ? 32'd0 : chain[0].x;
      FN_ORDER: value_next = chain[0].acc + 32'd1;
      FN_MAX:   value_next = chain[0].x;
      default:  value_next = 32'd0;
    endcase
    dep_next = (insert_total == WORD_MAX) ? WORD_MAX : insert_total - 32'(rank_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy         <= 1'b0;
      basis_rank   <= 6'd0;
      insert_total <= 32'd0;
      out_valid    <= 1'b0;
    end else begin
      if (accept) begin
        busy <= 1'b1;
        if (func == FN_INSERT && insert_total != WORD_MAX) begin
          insert_total <= insert_total + 32'd1;
        end
      end else if (finish) begin
        busy <= 1'b0;
      end
      if (finish) begin
        basis_rank <= rank_next;
        out_valid  <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      result_value    <= value_next;
      is_member       <= (chain[0].func == FN_MEMBER) && (chain[0].x == 32'd0);
      out_of_range    <= (chain[0].func == FN_KTH) && chain[0].oor;
      rank            <= rank_next;
      dependent_count <= dep_next;
    end
  end

endmodule

// File: rtl/xlb_checker.sv
// Port-level checks of the XOR linear basis unit, bound to the top level.
// Depends on xor_linear_basis_unit_defines.svh and the top level's ports.
`include "xor_linear_basis_unit_defines.svh"

module xlb_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] result_value,
  input logic        is_member,
  input logic        out_of_range,
  input logic [5:0]  rank,
  input logic [31:0] dependent_count
);

  `XLB_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && !in_stall, in_stall, "word accepted while another is in the chain")
  `XLB_ASSERT_NEXT(a_result_held, clk, rst, out_valid && out_stall, out_valid && $stable(result_value) && $stable(rank) && $stable(dependent_count), "stalled result changed")
  `XLB_ASSERT_NOW(a_flag_zero_value, clk, rst, out_valid && (is_member || out_of_range), result_value == 32'd0, "flagged result carries a value")
  `XLB_ASSERT_NOW(a_free_at_result, clk, rst, $rose(out_valid), !in_stall, "input still stalled when the result appears")

endmodule

bind xor_linear_basis_unit xlb_checker u_xlb_checker (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .result_value    (result_value),
  .is_member       (is_member),
  .out_of_range    (out_of_range),
  .rank            (rank),
  .dependent_count (dependent_count)
);

// File: test/xor_linear_basis_unit_tb.sv
// Self-checking testbench for the XOR linear basis unit: directed and random words
// checked against an in-bench predictor of the basis, rank and insert count.
// Depends on xlb_pkg and xor_linear_basis_unit.
`timescale 1ns / 100ps

module xor_linear_basis_unit_tb;
  import xlb_pkg::*;

  localparam logic [2:0] FN_SPARE_FIRST = 3'd5;
  localparam logic [2:0] FN_SPARE_LAST  = 3'd7;
  localparam int QUIET_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 40;
  localparam int RANDOM_WORDS = 590;

  typedef struct packed {
    logic [31:0] value;
    logic        member;
    logic        oor;
    logic [5:0]  rank;
    logic [31:0] dep;
  } basis_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  func = 3'd0;
  logic [31:0] operand = 32'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] result_value;
  logic        is_member;
  logic        out_of_range;
  logic [5:0]  rank;
  logic [31:0] dependent_count;

  logic [31:0] slot_q [32];
  logic [5:0]  basis_rank_q = 6'd0;
  logic [31:0] insert_cnt = 32'd0;

  basis_result_t pending_results [$];
  int error_count = 0;
  int quiet_cycles = 0;
  bit idle_enable = 1'b1;
  int burst_left = 0;
  int stall_mode = 0;
  int stall_seg_left = 0;
  int stall_phase = 0;

  xor_linear_basis_unit uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .func(func),
    .operand(operand),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .result_value(result_value),
    .is_member(is_member),
    .out_of_range(out_of_range),
    .rank(rank),
    .dependent_count(dependent_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    for (int i = 0; i < 32; i++) slot_q[i] = 32'd0;
  end

  function automatic logic [31:0] kth_smallest(logic [31:0] idx);
    logic [31:0] acc;
    int left;
    acc = 32'd0;
    left = int'(basis_rank_q);
    for (int i = 31; i >= 0; i--) begin
      if (slot_q[i] != 32'd0) begin
        left--;
        if (idx[left] != acc[i]) acc ^= slot_q[i];
      end
    end
    return acc;
  endfunction

  function automatic basis_result_t predict_result(logic [2:0] f, logic [31:0] x);
    basis_result_t r;
    logic [31:0] v;
    logic [32:0] lim;
    bit placed;
    r = '0;
    v = x;
    placed = 1'b0;
    case (f)
      FN_INSERT: begin
        if (insert_cnt != WORD_MAX) insert_cnt++;
        for (int i = 31; i >= 0; i--) begin
          if (!placed && v[i]) begin
            if (slot_q[i] == 32'd0) begin
              slot_q[i] = v;
              basis_rank_q++;
              placed = 1'b1;
            end else begin
              v ^= slot_q[i];
            end
          end
        end
      end
      FN_MEMBER: begin
        for (int i = 31; i >= 0; i--)
          if (v[i] && slot_q[i] != 32'd0) v ^= slot_q[i];
        r.member = (v == 32'd0);
      end
      FN_KTH: begin
        lim = 33'd1 << basis_rank_q;
        if (x == 32'd0 || {1'b0, x} > lim) r.oor = 1'b1;
        else r.value = kth_smallest(x - 32'd1);
      end
      FN_ORDER: begin
        v = 32'd0;
        for (int i = 31; i >= 0; i--)
          if (slot_q[i] != 32'd0) v = {v[30:0], x[i]};
        r.value = v + 32'd1;
      end
      FN_MAX: begin
        v = 32'd0;
        for (int i = 31; i >= 0; i--)
          if (slot_q[i] != 32'd0 && !v[i]) v ^= slot_q[i];
        r.value = v;
      end
      default: begin
      end
    endcase
    r.rank = basis_rank_q;
    r.dep = (insert_cnt == WORD_MAX) ? WORD_MAX : insert_cnt - 32'(basis_rank_q);
    return r;
  endfunction

  task automatic send_word(logic [2:0] f, logic [31:0] x);
    int gap;
    gap = 0;
    if (idle_enable) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 10);
        gap = $urandom_range(1, 12);
      end
      burst_left--;
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    func <= f;
    operand <= x;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results = {pending_results, predict_result(f, x)};
  endtask

  task automatic report_mismatch(string field, logic [31:0] exp_v, logic [31:0] act_v);
    $display("%0t: %s mismatch, expected %h, actual %h", $time, field, exp_v, act_v);
    error_count++;
  endtask

  // Each result word is compared with the oldest prediction.
  always @(posedge clk) begin
    basis_result_t e;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result word, actual value %h", $time, result_value);
        error_count++;
      end else begin
        e = pending_results.pop_front();
        if (result_value !== e.value) report_mismatch("result_value", e.value, result_value);
        if (is_member !== e.member)
          report_mismatch("is_member", 32'(e.member), 32'(is_member));
        if (out_of_range !== e.oor)
          report_mismatch("out_of_range", 32'(e.oor), 32'(out_of_range));
        if (rank !== e.rank) report_mismatch("rank", 32'(e.rank), 32'(rank));
        if (dependent_count !== e.dep)
          report_mismatch("dependent_count", e.dep, dependent_count);
      end
    end
  end

  // The receiver switches between no stalls, random stalls and a fixed duty cycle.
  always @(posedge clk) begin
    if (stall_seg_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_seg_left = $urandom_range(20, 300);
    end
    stall_seg_left--;
    stall_phase++;
    case (stall_mode)
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ((stall_phase % 8) < 3);
      default: out_stall <= 1'b0;
    endcase
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic test_empty_basis();
    send_word(FN_MAX, 32'd0);
    send_word(FN_KTH, 32'd1);
    send_word(FN_KTH, 32'd2);
    send_word(FN_KTH, 32'd0);
    send_word(FN_MEMBER, 32'd0);
    send_word(FN_MEMBER, 32'd1);
    send_word(FN_ORDER, WORD_MAX);
    for (int f = FN_SPARE_FIRST; f <= FN_SPARE_LAST; f++) send_word(3'(f), WORD_MAX);
  endtask

  task automatic test_insert_directed();
    send_word(FN_INSERT, 32'd0);
    send_word(FN_INSERT, 32'h8000_0000);
    send_word(FN_INSERT, WORD_MAX);
    send_word(FN_INSERT, 32'h7FFF_FFFF);
    send_word(FN_INSERT, 32'd1);
  endtask

  task automatic test_query_directed();
    send_word(FN_MEMBER, 32'h7FFF_FFFE);
    send_word(FN_MEMBER, 32'd2);
    send_word(FN_KTH, 32'd4);
    send_word(FN_KTH, 32'd5);
    send_word(FN_KTH, WORD_MAX);
    send_word(FN_ORDER, WORD_MAX);
    send_word(FN_ORDER, 32'h8000_0000);
    send_word(FN_MAX, 32'd0);
  endtask

  task automatic test_random_mix();
    int sel;
    int sub;
    logic [32:0] lim;
    logic [31:0] x;
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n % 100 == 0) idle_enable = $urandom_range(0, 2) != 0;
      sel = $urandom_range(0, 99);
      sub = $urandom_range(0, 9);
      lim = 33'd1 << basis_rank_q;
      if (sel < 15) begin
        if (sub == 0) x = 32'd0;
        else if (sub < 5) x = kth_smallest($urandom);
        else x = $urandom >> $urandom_range(0, 31);
        send_word(FN_INSERT, x);
      end else if (sel < 35) begin
        send_word(FN_MEMBER, (sub < 5) ? kth_smallest($urandom) : $urandom);
      end else if (sel < 60) begin
        case (sub % 6)
          0: x = 32'd0;
          1: x = 32'd1;
          2: x = lim[32] ? WORD_MAX : lim[31:0];
          3: x = lim[32] ? 32'($urandom) : lim[31:0] + 32'd1;
          4: x = $urandom_range(1, lim[32] ? WORD_MAX : lim[31:0]);
          default: x = $urandom;
        endcase
        send_word(FN_KTH, x);
      end else if (sel < 80) begin
        send_word(FN_ORDER, (sub < 5) ? kth_smallest($urandom) : $urandom);
      end else if (sel < 93) begin
        send_word(FN_MAX, $urandom);
      end else begin
        send_word(3'($urandom_range(FN_SPARE_FIRST, FN_SPARE_LAST)), $urandom);
      end
    end
  endtask

  task automatic test_full_rank();
    idle_enable = 1'b1;
    for (int i = 0; i < 32; i++) send_word(FN_INSERT, 32'd1 << i);
    send_word(FN_ORDER, WORD_MAX);
    send_word(FN_KTH, WORD_MAX);
    send_word(FN_MEMBER, $urandom);
    send_word(FN_MAX, 32'd0);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_basis();
    test_insert_directed();
    test_query_directed();
    test_random_mix();
    test_full_rank();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
